// File: rtl/msp_pkg.sv
// Shared types and constants for the multichannel sample player.
`default_nettype none

package msp_pkg;

    // Default sizes for the top-level parameters
    localparam int CHANNELS_DEF = 2;
    localparam int DEPTH_DEF    = 65536;

    // Field widths
    localparam int CMD_W    = 3;
    localparam int CH_W     = 3;
    localparam int ADDR_W   = 16;
    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 32;
    localparam int RATE_W   = 19;
    localparam int LEN_W    = 17;
    localparam int FRAC_W   = 16;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Command codes; the two spare codes are ignored
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 3'd0,
        CMD_WRITE    = 3'd1,
        CMD_PLAY     = 3'd2,
        CMD_STOP     = 3'd3,
        CMD_SPEED    = 3'd4,
        CMD_POSITION = 3'd5
    } cmd_t;

    // One job for the back end: a store write or a tick frame
    typedef struct packed {
        logic                       is_write;
        logic [CH_W-1:0]            channel;
        logic [ADDR_W-1:0]          address;
        logic signed [SAMPLE_W-1:0] value;
        logic                       active;
        logic [ADDR_W-1:0]          ipos;
        logic [FRAC_W-1:0]          frac;
        logic                       playing;
    } job_t;

endpackage

`default_nettype wire

// File: rtl/msp_cmd_if.sv
// Command channel: valid/ready handshake with the command item payload.
`default_nettype none

interface msp_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [msp_pkg::CMD_W-1:0]           command;
    logic [msp_pkg::CH_W-1:0]            channel;
    logic [msp_pkg::ADDR_W-1:0]          address;
    logic signed [msp_pkg::SAMPLE_W-1:0] sample_value;
    logic [msp_pkg::POS_W-1:0]           start_position;
    logic [msp_pkg::RATE_W-1:0]          rate;

    modport source (
        output valid, command, channel, address, sample_value, start_position, rate,
        input  ready
    );
    modport sink (
        input  valid, command, channel, address, sample_value, start_position, rate,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/msp_smp_if.sv
// Sample channel: valid/ready handshake with the output sample item payload.
`default_nettype none

interface msp_smp_if;
    logic                                valid;
    logic                                ready;
    logic [msp_pkg::CH_W-1:0]            out_channel;
    logic signed [msp_pkg::SAMPLE_W-1:0] out_sample;
    logic                                last_of_frame;
    logic                                is_playing;

    modport source (
        output valid, out_channel, out_sample, last_of_frame, is_playing,
        input  ready
    );
    modport sink (
        input  valid, out_channel, out_sample, last_of_frame, is_playing,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/multichannel_sample_player.sv
// Top level: variable-rate multichannel sample player with linear interpolation.
// Path: tick item -> queue slot -> store read and tag -> multiply -> output register.
// Throughput: one command item per cycle while the 4-deep job queue is not full;
//   the back end drains a store write as one job and a tick as one store read
//   pair per channel, issued one after another.
// Reset: rst_n clears play state, length, queue and pipeline valids; store is not cleared.
`default_nettype none

module multichannel_sample_player #(
    parameter int CHANNELS = msp_pkg::CHANNELS_DEF,
    parameter int DEPTH    = msp_pkg::DEPTH_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    msp_cmd_if.sink                        cmd,
    msp_smp_if.source                      smp,
    input  wire logic                      cfg_we,
    input  wire logic [msp_pkg::LEN_W-1:0] cfg_wdata
);

    logic          push;
    logic          full;
    logic          pop;
    logic          empty;
    msp_pkg::job_t push_job;
    msp_pkg::job_t head;

    msp_front #(
        .CHANNELS (CHANNELS),
        .DEPTH    (DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .push_job  (push_job),
        .full      (full)
    );

    msp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    msp_back #(
        .CHANNELS (CHANNELS),
        .DEPTH    (DEPTH)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .empty (empty),
        .pop   (pop),
        .smp   (smp)
    );

endmodule

`default_nettype wire

// File: rtl/msp_ram.sv
// Generic single-write, dual-read RAM with registered read data.
`default_nettype none

module msp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Two registered read ports
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

// File: rtl/msp_front.sv
// Front end: takes command items, keeps play state, queues writes and tick frames.
`default_nettype none

module msp_front #(
    parameter int CHANNELS = msp_pkg::CHANNELS_DEF,
    parameter int DEPTH    = msp_pkg::DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    msp_cmd_if.sink                            cmd,
    input  wire logic                          cfg_we,
    input  wire logic [msp_pkg::LEN_W-1:0]     cfg_wdata,
    output logic                               push,
    output msp_pkg::job_t                      push_job,
    input  wire logic                          full
);

    localparam logic [msp_pkg::LEN_W-1:0] DEPTH_LEN = msp_pkg::LEN_W'(DEPTH);
    localparam logic [msp_pkg::CH_W:0]    CH_LIMIT  = (msp_pkg::CH_W + 1)'(CHANNELS);

    logic                          playing_reg, playing_next;
    logic [msp_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [msp_pkg::RATE_W-1:0]    speed_reg, speed_next;
    logic [msp_pkg::LEN_W-1:0]     len_reg;

    logic                          accept;
    logic [msp_pkg::LEN_W-1:0]     eff_len;
    logic [msp_pkg::ADDR_W-1:0]    ipos;
    logic                          at_end;
    logic                          len_ok;
    logic                          tick_active;
    logic                          tick_playing;
    logic [msp_pkg::POS_W:0]       pos_sum;
    logic [msp_pkg::POS_W-1:0]     pos_adv;
    logic                          write_ok;

    assign cmd.ready = !full;
    assign accept    = cmd.valid && !full;

    // Tick decode: effective length, end test, saturating advance
    assign eff_len      = (len_reg < DEPTH_LEN) ? len_reg : DEPTH_LEN;
    assign ipos         = pos_reg[msp_pkg::POS_W-1:msp_pkg::FRAC_W];
    assign at_end       = ({1'b0, ipos} + msp_pkg::LEN_W'(1)) >= eff_len;
    assign len_ok       = (eff_len != '0);
    assign tick_active  = playing_reg && len_ok && !at_end;
    assign tick_playing = playing_reg && !(len_ok && at_end);
    assign pos_sum      = {1'b0, pos_reg} + (msp_pkg::POS_W + 1)'(speed_reg);
    assign pos_adv      = pos_sum[msp_pkg::POS_W] ? '1 : pos_sum[msp_pkg::POS_W-1:0];

    // Writes outside the store are dropped here
    assign write_ok = ({1'b0, cmd.channel} < CH_LIMIT) && ({1'b0, cmd.address} < DEPTH_LEN);

    // Next play state and queue push
    always_comb
    begin
        playing_next = playing_reg;
        pos_next     = pos_reg;
        speed_next   = speed_reg;
        push         = 1'b0;

        push_job.is_write = 1'b0;
        push_job.channel  = cmd.channel;
        push_job.address  = cmd.address;
        push_job.value    = cmd.sample_value;
        push_job.active   = tick_active;
        push_job.ipos     = ipos;
        push_job.frac     = pos_reg[msp_pkg::FRAC_W-1:0];
        push_job.playing  = tick_playing;

        if (accept)
        begin
            case (cmd.command)
                msp_pkg::CMD_TICK:
                begin
                    push         = 1'b1;
                    playing_next = tick_playing;
                    if (tick_active)
                    begin
                        pos_next = pos_adv;
                    end
                end
                msp_pkg::CMD_WRITE:
                begin
                    push_job.is_write = 1'b1;
                    push              = write_ok;
                end
                msp_pkg::CMD_PLAY:
                begin
                    playing_next = 1'b1;
                    pos_next     = cmd.start_position;
                    speed_next   = cmd.rate;
                end
                msp_pkg::CMD_STOP:
                begin
                    playing_next = 1'b0;
                end
                msp_pkg::CMD_SPEED:
                begin
                    speed_next = cmd.rate;
                end
                msp_pkg::CMD_POSITION:
                begin
                    pos_next = cmd.start_position;
                end
                default:
                begin
                    playing_next = playing_reg;
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            playing_reg <= 1'b0;
            pos_reg     <= '0;
            speed_reg   <= '0;
            len_reg     <= '0;
        end
        else
        begin
            playing_reg <= playing_next;
            pos_reg     <= pos_next;
            speed_reg   <= speed_next;
            if (cfg_we)
            begin
                len_reg <= cfg_wdata;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/msp_queue.sv
// Short job queue that decouples the front end from the back end.
`default_nettype none

module msp_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire msp_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output msp_pkg::job_t      head,
    output logic               empty
);

    msp_pkg::job_t               slot_reg [msp_pkg::QUEUE_DEPTH];
    logic [msp_pkg::QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [msp_pkg::QCNT_W-1:0]  count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == msp_pkg::QCNT_W'(msp_pkg::QUEUE_DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// File: rtl/msp_back.sv
// Back end: performs store writes and streams one interpolated sample per channel.
`default_nettype none

module msp_back #(
    parameter int CHANNELS = msp_pkg::CHANNELS_DEF,
    parameter int DEPTH    = msp_pkg::DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire msp_pkg::job_t head,
    input  wire logic          empty,
    output logic               pop,
    msp_smp_if.source          smp
);

    localparam int IDXW      = $clog2(DEPTH);
    localparam int RAM_DEPTH = CHANNELS * (1 << IDXW);
    localparam int AW        = $clog2(RAM_DEPTH);
    localparam logic [msp_pkg::CH_W-1:0] LAST_CH = msp_pkg::CH_W'(CHANNELS - 1);

    typedef struct packed {
        logic [msp_pkg::CH_W-1:0]   channel;
        logic                       active;
        logic [msp_pkg::FRAC_W-1:0] frac;
        logic                       playing;
        logic                       last;
    } meta_t;

    logic                               adv;
    logic                               issue;
    logic                               do_write;
    logic [msp_pkg::CH_W-1:0]           ch_reg;
    logic [IDXW-1:0]                    idx_a, idx_b;
    logic [AW-1:0]                      waddr, raddr_a, raddr_b;
    logic [msp_pkg::SAMPLE_W-1:0]       rd_a, rd_b;

    logic                               v1_reg, v2_reg, out_valid_reg;
    meta_t                              m1_reg, m2_reg, m_issue;
    logic signed [msp_pkg::SAMPLE_W-1:0] a2_reg;
    logic signed [msp_pkg::SAMPLE_W:0]  diff;
    logic signed [2*msp_pkg::SAMPLE_W+1:0] prod, prod2_reg;
    logic signed [msp_pkg::SAMPLE_W+1:0] interp;

    logic [msp_pkg::CH_W-1:0]           out_ch_reg;
    logic signed [msp_pkg::SAMPLE_W-1:0] out_sample_reg;
    logic                               out_last_reg, out_playing_reg;

    // Whole pipeline moves when the output register is free or being taken
    assign adv      = !out_valid_reg || smp.ready;
    assign issue    = adv && !empty && !head.is_write;
    assign do_write = adv && !empty && head.is_write;
    assign pop      = do_write || (issue && (ch_reg == LAST_CH));

    // Store addressing: channel above sample index
    assign idx_a   = head.ipos[IDXW-1:0];
    assign idx_b   = idx_a + 1'b1;
    assign waddr   = AW'({head.channel, head.address[IDXW-1:0]});
    assign raddr_a = AW'({ch_reg, idx_a});
    assign raddr_b = AW'({ch_reg, idx_b});

    msp_ram #(
        .WIDTH (msp_pkg::SAMPLE_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (do_write),
        .waddr   (waddr),
        .wdata   (head.value),
        .re      (adv),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // Per-channel item tags
    assign m_issue.channel = ch_reg;
    assign m_issue.active  = head.active;
    assign m_issue.frac    = head.frac;
    assign m_issue.playing = head.playing;
    assign m_issue.last    = (ch_reg == LAST_CH);

    // frac * (b - a); the low 16 bits of a*65536 are zero, so floor is a + (p >>> 16)
    assign diff   = $signed({rd_b[msp_pkg::SAMPLE_W-1], rd_b})
                  - $signed({rd_a[msp_pkg::SAMPLE_W-1], rd_a});
    assign prod   = $signed({1'b0, m1_reg.frac}) * diff;
    assign interp = $signed({{2{a2_reg[msp_pkg::SAMPLE_W-1]}}, a2_reg})
                  + prod2_reg[2*msp_pkg::SAMPLE_W+1:msp_pkg::FRAC_W];

    // Control: channel counter and stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg        <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= issue;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
            if (issue)
            begin
                ch_reg <= (ch_reg == LAST_CH) ? '0 : ch_reg + 1'b1;
            end
        end
    end

    // Datapath stages: tag, multiply, add into the output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_reg          <= m_issue;
            m2_reg          <= m1_reg;
            a2_reg          <= $signed(rd_a);
            prod2_reg       <= prod;
            out_ch_reg      <= m2_reg.channel;
            out_sample_reg  <= m2_reg.active ? interp[msp_pkg::SAMPLE_W-1:0] : '0;
            out_last_reg    <= m2_reg.last;
            out_playing_reg <= m2_reg.playing;
        end
    end

    assign smp.valid         = out_valid_reg;
    assign smp.out_channel   = out_ch_reg;
    assign smp.out_sample    = out_sample_reg;
    assign smp.last_of_frame = out_last_reg;
    assign smp.is_playing    = out_playing_reg;

endmodule

`default_nettype wire

// File: rtl/msp_checker.sv
// Port-level checker for the sample player output, bound to the top level.
`default_nettype none

module msp_checker #(
    parameter int CHANNELS = msp_pkg::CHANNELS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    msp_smp_if.source  smp
);

    localparam logic [msp_pkg::CH_W-1:0] LAST_CH = msp_pkg::CH_W'(CHANNELS - 1);

    // A stalled item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        smp.valid && !smp.ready |=> smp.valid)
        else $error("output valid dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        smp.valid && !smp.ready |=> $stable(smp.out_sample) && $stable(smp.out_channel))
        else $error("output item changed while stalled");

    // Frame mark sits on the last channel only
    assert property (@(posedge clk) disable iff (!rst_n)
        smp.valid |-> (smp.last_of_frame == (smp.out_channel == LAST_CH)))
        else $error("last_of_frame does not match final channel");

    // Not playing after the tick means a silent sample
    assert property (@(posedge clk) disable iff (!rst_n)
        smp.valid && !smp.is_playing |-> (smp.out_sample == '0))
        else $error("nonzero sample while stopped");

endmodule

bind multichannel_sample_player msp_checker #(
    .CHANNELS (CHANNELS)
) u_msp_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .smp   (smp)
);

`default_nettype wire
